// ----- rtl/bmhq_pkg.sv -----
package bmhq_pkg;

    localparam int KEY_W        = 31;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;
    localparam int CAPACITY_DEF = 1024;

    localparam logic [KEY_W-1:0] EMPTY_MARK = 31'd2000000000;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_EXTRACT  = 2'd1,
        MODE_DECREASE = 2'd2,
        MODE_DELETE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_LAST_RD,
        S_LAST_WAIT,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMPR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   index;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0]   removed_key;
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic [KEY_W-1:0]   min_key;
        logic               min_valid;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

endpackage

// ----- rtl/bmhq_ram.sv -----
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bmhq_core.sv -----
module bmhq_core
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_in_item  i_item,
    output t_core_sts o_sts,
    output t_out_item o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (IDX_W > CW) ? IDX_W : CW;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [KEY_W-1:0] r_cur, n_cur;
    logic [KEY_W-1:0] r_m, n_m;
    logic [KEY_W-1:0] r_root, n_root;
    logic [KEY_W-1:0] r_removed, n_removed;
    t_status         r_status, n_status;
    logic            r_bl, n_bl;
    logic            r_rc_ok, n_rc_ok;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [KEY_W-1:0] wdata, rdata;

    logic [AW-1:0]    parent;
    logic [AW+1:0]    lc, rc, cnt_x;
    logic [KEY_W-1:0] cmp_a, cmp_b;
    logic             cmp_lt;
    logic             idx_ok, cnt_zero, cnt_one;

    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign parent   = (r_pos - 1'b1) >> 1;
    assign lc       = {1'b0, r_pos, 1'b1};
    assign rc       = lc + 1'b1;
    assign cnt_x    = (AW+2)'(r_cnt);
    assign idx_ok   = XW'(i_item.index) < XW'(r_cnt);
    assign cnt_zero = (r_cnt == '0);
    assign cnt_one  = (r_cnt == CW'(1));

    // the one key comparator, time-shared by every sift step
    assign cmp_lt = cmp_a < cmp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos     <= n_pos;
        r_cur     <= n_cur;
        r_m       <= n_m;
        r_root    <= n_root;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_bl      <= n_bl;
        r_rc_ok   <= n_rc_ok;
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_m       = r_m;
        n_removed = r_removed;
        n_status  = r_status;
        n_bl      = r_bl;
        n_rc_ok   = r_rc_ok;
        we        = 1'b0;
        waddr     = r_pos;
        wdata     = r_cur;
        raddr     = '0;
        cmp_a     = r_cur;
        cmp_b     = rdata;

        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_removed = '0;
                    n_status  = STAT_OK;
                    n_cur     = i_item.key;
                    case (i_item.mode)
                        MODE_INSERT: begin
                            if (r_cnt == CAP_CNT) begin
                                n_status = STAT_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_pos   = AW'(r_cnt);
                                n_cnt   = r_cnt + 1'b1;
                                n_state = S_UP_RD;
                            end
                        end
                        MODE_EXTRACT: begin
                            if (cnt_zero) begin
                                n_removed = EMPTY_MARK;
                                n_status  = STAT_EMPTY;
                                n_state   = S_DONE;
                            end else begin
                                n_removed = r_root;
                                n_cnt     = r_cnt - 1'b1;
                                n_state   = cnt_one ? S_DONE : S_LAST_RD;
                            end
                        end
                        MODE_DECREASE: begin
                            if (!idx_ok) begin
                                n_status = STAT_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_pos   = AW'(i_item.index);
                                n_state = S_UP_RD;
                            end
                        end
                        MODE_DELETE: begin
                            if (!idx_ok) begin
                                n_status = STAT_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_pos   = AW'(i_item.index);
                                n_state = S_DEL_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // sift up: moving key stays in r_cur, the hole walks toward the root
            S_UP_RD: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    raddr   = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (cmp_lt) begin
                    wdata   = rdata;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // delete: shift each ancestor down one level, root becomes the hole
            S_DEL_RD: begin
                if (r_pos == '0) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = cnt_one ? S_DONE : S_LAST_RD;
                end else begin
                    raddr   = parent;
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                we      = 1'b1;
                wdata   = rdata;
                n_pos   = parent;
                n_state = S_DEL_RD;
            end

            // fetch the last entry, then sift it down from the root
            S_LAST_RD: begin
                raddr   = AW'(r_cnt);
                n_state = S_LAST_WAIT;
            end
            S_LAST_WAIT: begin
                n_cur   = rdata;
                n_pos   = '0;
                n_state = S_DN_RDL;
            end

            S_DN_RDL: begin
                if (lc >= cnt_x) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    raddr   = lc[AW-1:0];
                    n_rc_ok = rc < cnt_x;
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                // left child on rdata
                cmp_a = rdata;
                cmp_b = r_cur;
                n_m   = cmp_lt ? rdata : r_cur;
                n_bl  = cmp_lt;
                if (r_rc_ok) begin
                    raddr   = rc[AW-1:0];
                    n_state = S_DN_CMPR;
                end else begin
                    we = 1'b1;
                    if (cmp_lt) begin
                        wdata   = rdata;
                        n_pos   = lc[AW-1:0];
                        n_state = S_DN_RDL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DN_CMPR: begin
                // right child on rdata, against the smaller of left and moving key
                cmp_a = rdata;
                cmp_b = r_m;
                we    = 1'b1;
                if (cmp_lt) begin
                    wdata   = rdata;
                    n_pos   = rc[AW-1:0];
                    n_state = S_DN_RDL;
                end else if (r_bl) begin
                    wdata   = r_m;
                    n_pos   = lc[AW-1:0];
                    n_state = S_DN_RDL;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_root = (we && waddr == '0) ? wdata : r_root;
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = (r_state == S_DONE);

    assign o_result.removed_key = r_removed;
    assign o_result.status      = r_status;
    assign o_result.count       = CNT_W'(r_cnt);
    assign o_result.min_key     = cnt_zero ? '0 : r_root;
    assign o_result.min_valid   = !cnt_zero;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_CNT)
        else $error("heap count above capacity");

    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (CW'(waddr) < r_cnt))
        else $error("write outside the occupied heap");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == S_IDLE))
        else $error("start while busy");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_cnt != $past(r_cnt)) |->
            (r_cnt == $past(r_cnt) + 1'b1 || r_cnt == $past(r_cnt) - 1'b1))
        else $error("count moved by more than one");
`endif

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
// Binary min-heap priority queue over 31-bit keys.
// Input channel: i_in_valid / o_in_stall / i_in_data (mode, key, index).
// Output channel: o_out_valid / i_out_stall / o_out_data, one beat per input beat.
// Modes: insert, extract minimum, decrease key at index, delete at index.
// Every result carries the count and the current minimum after the operation.
// One item is worked at a time; o_in_stall is high from acceptance until the
// result is moved to the output register. The keys live in a single RAM with
// one write and one registered read port, and a single comparator does all
// ordering decisions, so the time is set by the sift walk over that port.
// Insert and decrease key walk the key up toward the root until it stops;
// extract moves the last entry to the root and sifts it down; delete first
// shifts each ancestor of the index down one level, then works as extract.
// Removing the last key skips the sift; full, empty and out-of-range cases
// finish without touching the heap.
// The next item is taken while a result still waits in the output register;
// if i_out_stall holds, the following result waits in the core.
// Synchronous active-low reset empties the heap and drops any pending beat;
// the key RAM is not cleared, only entries that hold heap keys are ever used.
module binary_min_heap_queue
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_core_ctl core_ctl;
    t_core_sts core_sts;
    t_out_item core_result;

    logic      r_out_valid;
    t_out_item r_out;
    logic      take;

    bmhq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_item   (i_in_data),
        .o_sts    (core_sts),
        .o_result (core_result)
    );

    assign take           = core_sts.done && (!r_out_valid || !i_out_stall);
    assign core_ctl.start = i_in_valid && !core_sts.busy;
    assign core_ctl.take  = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= core_result;
        end
    end

    assign o_in_stall  = core_sts.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
